// ===== rtl/msif_pkg.sv =====
// Shared types and constants of the message-signalled interrupt file.
package msif_pkg;

    localparam int ID_W   = 11;
    localparam int WORD_W = 5;
    localparam int BIT_W  = 6;
    localparam int DATA_W = 64;

    localparam logic [7:0] SEL_DELIVERY  = 8'h70;
    localparam logic [7:0] SEL_THRESHOLD = 8'h72;
    localparam logic [7:0] SEL_PENDING   = 8'h80;
    localparam logic [7:0] SEL_ENABLE    = 8'hc0;
    localparam int         DELIVERY_BIT  = 0;

    typedef enum logic [1:0] {
        OP_MSG   = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_CLAIM = 2'd3
    } op_t;

    // Updates broadcast to every word cell in the cycle an item is accepted.
    typedef struct packed {
        logic              msg_set;
        logic [WORD_W-1:0] msg_word;
        logic [BIT_W-1:0]  msg_bit;
        logic              pend_wr;
        logic              en_wr;
        logic [WORD_W-1:0] wr_word;
        logic [DATA_W-1:0] wdata;
        logic              clr;
        logic [WORD_W-1:0] clr_word;
        logic [BIT_W-1:0]  clr_bit;
    } upd_t;

    // Word read request, held for the whole scan.
    typedef struct packed {
        logic              pend;
        logic              en;
        logic [WORD_W-1:0] word;
    } rd_t;

    // What each cell hands to its neighbour.
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] rdata;
    } link_t;

endpackage

// ===== rtl/msif_req_if.sv =====
// Request channel: one access or message item.
interface msif_req_if;
    import msif_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [7:0]        reg_select;
    logic [DATA_W-1:0] write_data;
    logic [ID_W-1:0]   msi_identity;

    modport source (output valid, op, reg_select, write_data, msi_identity, input ready);
    modport sink   (input valid, op, reg_select, write_data, msi_identity, output ready);
endinterface

// ===== rtl/msif_rsp_if.sv =====
// Response channel: one result item per request.
interface msif_rsp_if;
    import msif_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              bad_select;
    logic [ID_W-1:0]   top_identity;
    logic              irq;

    modport source (output valid, read_data, bad_select, top_identity, irq, input ready);
    modport sink   (input valid, read_data, bad_select, top_identity, irq, output ready);
endinterface

// ===== rtl/msi_interrupt_file_core.sv =====
// Top level of the message-signalled interrupt file.
// The pending and enable bits live in a row of word cells, one per 64
// identities. An item is applied when it is accepted. The search for the
// lowest pending enabled identity, and any word read, then ripple along the
// row one cell per cycle. The result moves into the output register once the
// search has passed the last cell and the output register is free, and the
// next item can be accepted in the cycle after that, so only one item is in the
// row at a time. A new item is taken as soon as the previous result has moved
// into the output register, even while that result waits to be collected. A
// claim returns the top identity found after the previous item.
module msi_interrupt_file_core #(
    parameter int NUM_IDS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    msif_req_if.sink   request,
    msif_rsp_if.source response
);
    import msif_pkg::*;

    localparam int ID_WORDS = (NUM_IDS + 63) / 64;
    localparam int CNT_W    = $clog2(ID_WORDS + 1);
    localparam logic [ID_W:0] NUM_IDS_L = (ID_W + 1)'(NUM_IDS);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              deliv_reg;
    logic [ID_W-1:0]   thr_reg;
    logic [ID_W-1:0]   top_reg;
    logic              bad_reg;
    logic [DATA_W-1:0] base_reg;
    rd_t               rd_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_bad_reg;
    logic [ID_W-1:0]   out_top_reg;
    logic              out_irq_reg;

    logic              accept;
    logic              finish;
    logic              is_rw;
    logic              is_word;
    logic              is_bad;
    logic              id_ok;
    logic [ID_W-1:0]   new_top;
    upd_t              upd;
    rd_t               rd_next;
    logic [DATA_W-1:0] base_next;
    link_t             links [ID_WORDS+1];

    assign request.ready = !busy_reg;
    assign accept        = request.valid && !busy_reg;
    assign finish        = busy_reg && (cnt_reg == '0) && (!out_valid_reg || response.ready);

    assign is_rw   = (request.op == OP_READ) || (request.op == OP_WRITE);
    assign is_word = request.reg_select[7] && !request.reg_select[0];
    assign is_bad  = is_rw && !(request.reg_select == SEL_DELIVERY ||
                                request.reg_select == SEL_THRESHOLD || is_word);
    assign id_ok   = (request.msi_identity != '0) && ({1'b0, request.msi_identity} < NUM_IDS_L);

    always_comb
    begin
        upd          = '0;
        upd.msg_word = request.msi_identity[ID_W-1:BIT_W];
        upd.msg_bit  = request.msi_identity[BIT_W-1:0];
        upd.wr_word  = request.reg_select[WORD_W:1];
        upd.wdata    = request.write_data;
        upd.clr_word = top_reg[ID_W-1:BIT_W];
        upd.clr_bit  = top_reg[BIT_W-1:0];
        rd_next      = '0;
        rd_next.word = request.reg_select[WORD_W:1];
        base_next    = '0;
        if (accept)
        begin
            case (request.op)
                OP_MSG:
                begin
                    upd.msg_set = id_ok;
                end
                OP_READ:
                begin
                    // Pending words sit below the enable words (select bit 6).
                    rd_next.pend = is_word && !request.reg_select[6];
                    rd_next.en   = is_word && request.reg_select[6];
                    if (request.reg_select == SEL_DELIVERY)
                    begin
                        base_next = DATA_W'(deliv_reg);
                    end
                    else if (request.reg_select == SEL_THRESHOLD)
                    begin
                        base_next = DATA_W'(thr_reg);
                    end
                end
                OP_WRITE:
                begin
                    upd.pend_wr = is_word && !request.reg_select[6];
                    upd.en_wr   = is_word && request.reg_select[6];
                end
                OP_CLAIM:
                begin
                    upd.clr   = (top_reg != '0);
                    base_next = {37'd0, top_reg, 5'd0, top_reg};
                end
                default:
                begin
                    upd.msg_set = 1'b0;
                end
            endcase
        end
    end

    assign links[0] = '{found: 1'b0, id: '0, rdata: base_reg};

    for (genvar i = 0; i < ID_WORDS; i++)
    begin : g_cell
        msif_cell #(
            .INDEX   (i),
            .NUM_IDS (NUM_IDS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .upd      (upd),
            .rd       (rd_reg),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    // A found identity at or above a nonzero threshold masks everything.
    assign new_top = (links[ID_WORDS].found &&
                      (thr_reg == '0 || links[ID_WORDS].id < thr_reg)) ?
                     links[ID_WORDS].id : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            deliv_reg     <= 1'b0;
            thr_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ID_WORDS);
                if (request.op == OP_WRITE && request.reg_select == SEL_DELIVERY)
                begin
                    deliv_reg <= request.write_data[DELIVERY_BIT];
                end
                if (request.op == OP_WRITE && request.reg_select == SEL_THRESHOLD)
                begin
                    thr_reg <= request.write_data[ID_W-1:0];
                end
            end
            else if (busy_reg && cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (finish)
            begin
                busy_reg      <= 1'b0;
                top_reg       <= new_top;
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bad_reg  <= is_bad;
            base_reg <= base_next;
            rd_reg   <= rd_next;
        end
        if (finish)
        begin
            out_data_reg <= links[ID_WORDS].rdata;
            out_bad_reg  <= bad_reg;
            out_top_reg  <= new_top;
            out_irq_reg  <= deliv_reg && (new_top != '0);
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.read_data    = out_data_reg;
    assign response.bad_select   = out_bad_reg;
    assign response.top_identity = out_top_reg;
    assign response.irq          = out_irq_reg;

endmodule

// ===== rtl/msif_cell.sv =====
// One word cell: 64 pending and enable bits, local priority encode and chain stage.
module msif_cell #(
    parameter int INDEX   = 0,
    parameter int NUM_IDS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  msif_pkg::upd_t  upd,
    input  msif_pkg::rd_t   rd,
    input  msif_pkg::link_t link_in,
    output msif_pkg::link_t link_out
);
    import msif_pkg::*;

    localparam int BASE = INDEX * 64;
    localparam int LIVE = ((NUM_IDS - BASE) >= 64) ? 64 : (NUM_IDS - BASE);
    localparam logic [DATA_W-1:0] LIVE_MASK =
        (LIVE >= 64) ? {DATA_W{1'b1}} : ((64'd1 << LIVE) - 64'd1);
    // Identity zero is never implemented.
    localparam logic [DATA_W-1:0] MASK =
        (INDEX == 0) ? (LIVE_MASK & ~64'd1) : LIVE_MASK;
    localparam logic [WORD_W-1:0] IDX = WORD_W'(INDEX);

    logic [DATA_W-1:0] pend_reg, pend_next;
    logic [DATA_W-1:0] en_reg, en_next;
    logic [DATA_W-1:0] hits;
    logic [BIT_W-1:0]  lowest;
    link_t             link_reg, link_next;

    always_comb
    begin
        pend_next = pend_reg;
        en_next   = en_reg;
        if (upd.msg_set && upd.msg_word == IDX)
        begin
            pend_next[upd.msg_bit] = 1'b1;
        end
        if (upd.pend_wr && upd.wr_word == IDX)
        begin
            pend_next = upd.wdata & MASK;
        end
        if (upd.en_wr && upd.wr_word == IDX)
        begin
            en_next = upd.wdata & MASK;
        end
        if (upd.clr && upd.clr_word == IDX)
        begin
            pend_next[upd.clr_bit] = 1'b0;
        end
    end

    assign hits = pend_reg & en_reg;

    always_comb
    begin
        lowest = '0;
        for (int b = DATA_W - 1; b >= 0; b--)
        begin
            if (hits[b])
            begin
                lowest = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        link_next = link_in;
        if (!link_in.found && (|hits))
        begin
            link_next.found = 1'b1;
            link_next.id    = {IDX, lowest};
        end
        if (rd.pend && rd.word == IDX)
        begin
            link_next.rdata = pend_reg;
        end
        else if (rd.en && rd.word == IDX)
        begin
            link_next.rdata = en_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            en_reg         <= '0;
            link_reg.found <= 1'b0;
            link_reg.id    <= '0;
            link_reg.rdata <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            en_reg   <= en_next;
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== dv/tb_msi_interrupt_file_core.sv =====
// Self-checking testbench for the message-signalled interrupt file core.
`timescale 1ns / 100ps

module tb_msi_interrupt_file_core;
    import msif_pkg::*;

    localparam int NUM_IDS     = 64;
    localparam int ID_WORDS    = (NUM_IDS + 63) / 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bad_select;
        logic [ID_W-1:0]   top_identity;
        logic              irq;
    } file_response_t;

    logic clk;
    logic rst_n;

    msif_req_if req_ch ();
    msif_rsp_if rsp_ch ();

    msi_interrupt_file_core #(
        .NUM_IDS (NUM_IDS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch.sink),
        .response (rsp_ch.source)
    );

    // Shadow copy of the interrupt file state.
    logic [63:0]     pend_words [ID_WORDS];
    logic [63:0]     en_words [ID_WORDS];
    logic [ID_W-1:0] threshold;
    logic            delivery;

    file_response_t expected_responses [$];

    int errors;
    int n_checked;
    int n_claim_hits;
    int n_irq;
    int n_bad;
    int cycle_count;
    bit src_idle;
    bit snk_idle;
    int hold_len;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] word_mask(input int w);
        logic [63:0] m;
        int          base;
        m    = '1;
        base = w * 64;
        if (base >= NUM_IDS)
            return '0;
        if (NUM_IDS - base < 64)
            m = (64'd1 << (NUM_IDS - base)) - 64'd1;
        if (w == 0)
            m[0] = 1'b0;
        return m;
    endfunction

    // Lowest identity that is both pending and enabled, gated by the threshold.
    function automatic logic [ID_W-1:0] lowest_ready_id();
        for (int id = 1; id < NUM_IDS; id++)
        begin
            if (pend_words[id / 64][id % 64] && en_words[id / 64][id % 64])
            begin
                if (threshold != 0 && id >= threshold)
                    return '0;
                return ID_W'(id);
            end
        end
        return '0;
    endfunction

    function automatic file_response_t apply_item(input op_t op, input logic [7:0] sel,
                                                  input logic [63:0] data,
                                                  input logic [ID_W-1:0] ident);
        file_response_t r;
        int             w;
        logic [ID_W-1:0] top;
        r = '0;
        case (op)
            OP_MSG:
            begin
                if (ident != 0 && ident < NUM_IDS)
                    pend_words[ident / 64][ident % 64] = 1'b1;
            end
            OP_READ, OP_WRITE:
            begin
                if (sel == SEL_DELIVERY)
                begin
                    if (op == OP_WRITE)
                        delivery = data[DELIVERY_BIT];
                    else
                        r.read_data = 64'(delivery);
                end
                else if (sel == SEL_THRESHOLD)
                begin
                    if (op == OP_WRITE)
                        threshold = data[ID_W-1:0];
                    else
                        r.read_data = 64'(threshold);
                end
                else if (sel >= SEL_PENDING && !sel[0])
                begin
                    w = int'(((sel - SEL_PENDING) & 8'h3f) >> 1);
                    // Even words past the last identity read as zero without an error.
                    if (w < ID_WORDS)
                    begin
                        if (sel >= SEL_ENABLE)
                        begin
                            if (op == OP_WRITE)
                                en_words[w] = data & word_mask(w);
                            else
                                r.read_data = en_words[w] & word_mask(w);
                        end
                        else
                        begin
                            if (op == OP_WRITE)
                                pend_words[w] = data & word_mask(w);
                            else
                                r.read_data = pend_words[w] & word_mask(w);
                        end
                    end
                end
                else
                    r.bad_select = 1'b1;
            end
            default:
            begin
                top = lowest_ready_id();
                if (top != 0)
                begin
                    r.read_data = (64'(top) << 16) | 64'(top);
                    pend_words[top / 64][top % 64] = 1'b0;
                end
            end
        endcase
        r.top_identity = lowest_ready_id();
        r.irq          = delivery && (r.top_identity != 0);
        return r;
    endfunction

    task automatic send_item(input op_t op, input logic [7:0] sel, input logic [63:0] data,
                             input logic [ID_W-1:0] ident);
        int             gap;
        file_response_t r;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.reg_select   <= sel;
        req_ch.write_data   <= data;
        req_ch.msi_identity <= ident;
        do @(posedge clk); while (!req_ch.ready);
        r = apply_item(op, sel, data, ident);
        expected_responses.push_back(r);
        if (op == OP_CLAIM && r.read_data != 0)
            n_claim_hits++;
        if (r.irq)
            n_irq++;
        if (r.bad_select)
            n_bad++;
    endtask

    // Mostly well-formed traffic: identities in range and mapped selects.
    task automatic send_random_item();
        int              pick;
        int              r;
        op_t             op;
        logic [7:0]      sel;
        logic [63:0]     data;
        logic [ID_W-1:0] ident;
        pick  = $urandom_range(0, 99);
        data  = {$urandom, $urandom};
        ident = ID_W'($urandom_range(0, (1 << ID_W) - 1));
        sel   = 8'($urandom_range(0, 255));
        if (pick < 35)
        begin
            op = OP_MSG;
            if ($urandom_range(0, 9) != 0)
                ident = ID_W'($urandom_range(1, NUM_IDS - 1));
        end
        else if (pick < 70)
        begin
            op = (pick < 50) ? OP_READ : OP_WRITE;
            r  = $urandom_range(0, 9);
            if (r < 2)
                sel = SEL_DELIVERY;
            else if (r < 4)
                sel = SEL_THRESHOLD;
            else if (r < 6)
                sel = SEL_PENDING;
            else if (r < 8)
                sel = SEL_ENABLE;
            else if (r == 8)
                sel[0] = 1'b0;
            if (sel == SEL_THRESHOLD)
            begin
                r = $urandom_range(0, 3);
                if (r < 2)
                    data = '0;
                else if (r == 2)
                    data = 64'($urandom_range(0, NUM_IDS + 8));
            end
        end
        else
            op = OP_CLAIM;
        send_item(op, sel, data, ident);
    endtask

    task automatic test_reset_state();
        send_item(OP_READ, SEL_DELIVERY, '0, '0);
        send_item(OP_READ, SEL_THRESHOLD, '0, '0);
        send_item(OP_READ, SEL_PENDING, '0, '0);
        send_item(OP_READ, SEL_ENABLE, '0, '0);
    endtask

    task automatic test_messages();
        send_item(OP_MSG, '0, '1, '0);
        send_item(OP_MSG, '1, '0, '1);
        send_item(OP_MSG, '0, '0, ID_W'(NUM_IDS));
        send_item(OP_MSG, '0, '0, 11'd1);
        send_item(OP_MSG, '0, '0, ID_W'(NUM_IDS - 1));
        send_item(OP_MSG, '0, '0, 11'd40);
        send_item(OP_READ, SEL_PENDING, '0, '0);
    endtask

    task automatic test_claims();
        send_item(OP_CLAIM, '0, '0, '0);
        send_item(OP_WRITE, SEL_ENABLE, '1, '0);
        send_item(OP_WRITE, SEL_DELIVERY, '1, '0);
        send_item(OP_CLAIM, '0, '0, '0);
    endtask

    task automatic test_threshold();
        send_item(OP_WRITE, SEL_THRESHOLD, '1, '0);
        send_item(OP_READ, SEL_THRESHOLD, '0, '0);
        send_item(OP_WRITE, SEL_THRESHOLD, 64'd40, '0);
        send_item(OP_CLAIM, '0, '0, '0);
        send_item(OP_WRITE, SEL_THRESHOLD, '0, '0);
        send_item(OP_CLAIM, '0, '0, '0);
        send_item(OP_CLAIM, '0, '0, '0);
        send_item(OP_CLAIM, '0, '0, '0);
    endtask

    task automatic test_selects();
        send_item(OP_READ, SEL_DELIVERY + 8'd1, '0, '0);
        send_item(OP_WRITE, SEL_PENDING + 8'd1, '1, '0);
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_READ, SEL_ENABLE + 8'h3f, '0, '0);
        send_item(OP_WRITE, SEL_PENDING + 8'd2, '1, '0);
        send_item(OP_READ, SEL_ENABLE + 8'h3e, '0, '0);
        send_item(OP_WRITE, SEL_PENDING, '1, '0);
        send_item(OP_WRITE, SEL_DELIVERY, '0, '0);
    endtask

    task automatic test_random(input int count, input bit idle);
        src_idle = idle;
        snk_idle = idle;
        repeat (count) send_random_item();
    endtask

    // The receiver stops collecting while items keep coming, so the core backs up.
    task automatic test_backpressure();
        src_idle = 1'b0;
        hold_len = 60;
        repeat (30) send_random_item();
        src_idle = 1'b1;
    endtask

    initial
    begin
        errors              = 0;
        n_checked           = 0;
        n_claim_hits        = 0;
        n_irq               = 0;
        n_bad               = 0;
        src_idle            = 1'b1;
        snk_idle            = 1'b1;
        hold_len            = 0;
        threshold           = '0;
        delivery            = 1'b0;
        for (int w = 0; w < ID_WORDS; w++)
        begin
            pend_words[w] = '0;
            en_words[w]   = '0;
        end
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_MSG;
        req_ch.reg_select   = '0;
        req_ch.write_data   = '0;
        req_ch.msi_identity = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_messages();
        test_claims();
        test_threshold();
        test_selects();
        test_random(450, 1'b1);
        test_random(250, 1'b0);
        test_backpressure();
        test_random(420, 1'b1);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d responses: %0d successful claims, %0d with irq raised.",
                 n_checked, n_claim_hits, n_irq);
        $display("Covered %0d bad selects and one long output stall of 60 cycles.", n_bad);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: a random stall before each item while idle gaps are enabled, or a long hold when one is requested.
    initial
    begin : response_sink
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 7) : 0;
            if (hold_len > 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready) && hold_len == 0);
        end
    end

    always @(posedge clk)
    begin : check_response
        file_response_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t: response with none expected, read_data %h top_identity %0d",
                         $time, rsp_ch.read_data, rsp_ch.top_identity);
                errors++;
            end
            else
            begin
                want = expected_responses.pop_front();
                n_checked++;
                if (rsp_ch.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, rsp_ch.read_data);
                    errors++;
                end
                if (rsp_ch.bad_select !== want.bad_select)
                begin
                    $display("%0t: bad_select expected %b actual %b",
                             $time, want.bad_select, rsp_ch.bad_select);
                    errors++;
                end
                if (rsp_ch.top_identity !== want.top_identity)
                begin
                    $display("%0t: top_identity expected %0d actual %0d",
                             $time, want.top_identity, rsp_ch.top_identity);
                    errors++;
                end
                if (rsp_ch.irq !== want.irq)
                begin
                    $display("%0t: irq expected %b actual %b", $time, want.irq, rsp_ch.irq);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timed out with %0d responses outstanding",
                 $time, expected_responses.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
